[src/fsa_pkg.sv]
`default_nettype none
package fsa_pkg;

    localparam int WORD_W          = 32;
    localparam int NUM_DIGITS      = 10;
    localparam int BCD_W           = 4 * NUM_DIGITS;
    localparam int NUM_DD_STAGES   = 4;
    localparam int STEPS_PER_STAGE = WORD_W / NUM_DD_STAGES;
    localparam int NUM_CHARS       = 11;
    localparam int POS_W           = 4;

    localparam logic [POS_W-1:0] LAST_POS      = 4'd10;
    localparam logic [POS_W-1:0] HEX_START     = 4'd3;
    localparam logic [POS_W-1:0] PCT_START     = 4'd10;
    localparam logic [POS_W-1:0] UNK_START     = 4'd9;
    localparam logic [POS_W-1:0] DEC_MINUS_TOP = 4'd9;

    localparam logic [1:0] CMD_DEC = 2'd0;
    localparam logic [1:0] CMD_HEX = 2'd1;
    localparam logic [1:0] CMD_PCT = 2'd2;
    localparam logic [1:0] CMD_UNK = 2'd3;

    localparam logic [7:0] ASCII_ZERO    = 8'h30;
    localparam logic [7:0] ASCII_PERCENT = 8'h25;
    localparam logic [7:0] ASCII_MINUS   = 8'h2d;
    localparam logic [7:0] ASCII_SPACE   = 8'h20;

    localparam logic [7:0] HEX_TABLE [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] operand_word;
        logic [7:0]  spec_char;
    } fsa_req_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } fsa_rsp_t;

    // One request on its way through the binary-to-BCD stages.
    typedef struct packed {
        logic [1:0]        command;
        logic [7:0]        spec_char;
        logic              neg;
        logic [WORD_W-1:0] word;
        logic [BCD_W-1:0]  bcd;
        logic [WORD_W-1:0] shreg;
    } fsa_work_t;

    // Fully formatted request: characters right-aligned, end at LAST_POS.
    typedef struct packed {
        logic [NUM_CHARS-1:0][7:0] chars;
        logic [POS_W-1:0]          start;
    } fsa_fmt_t;

    // One double-dabble step: correct every digit of five or more, then
    // shift the next magnitude bit in.
    function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd,
                                                  input logic bit_in);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (adj[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], bit_in};
    endfunction

endpackage
`default_nettype wire

[src/fsa_dd_stage.sv]
`default_nettype none
module fsa_dd_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire fsa_pkg::fsa_work_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output fsa_pkg::fsa_work_t     out_data
);
    import fsa_pkg::*;

    logic      valid_reg;
    fsa_work_t data_reg;
    fsa_work_t data_next;

    // A fixed slice of the shift-and-add-3 conversion, one bit per step.
    always_comb
    begin
        data_next = in_data;
        for (int k = 0; k < STEPS_PER_STAGE; k++) begin
            data_next.bcd   = dd_step(data_next.bcd, data_next.shreg[WORD_W-1]);
            data_next.shreg = {data_next.shreg[WORD_W-2:0], 1'b0};
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end
endmodule
`default_nettype wire

[src/fsa_format.sv]
`default_nettype none
module fsa_format (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire fsa_pkg::fsa_work_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output fsa_pkg::fsa_fmt_t      out_data
);
    import fsa_pkg::*;

    logic             valid_reg;
    fsa_fmt_t         data_reg;
    fsa_fmt_t         data_next;
    logic [POS_W-1:0] msd;

    always_comb
    begin
        // Most significant nonzero digit; zero keeps a single digit.
        msd = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (in_data.bcd[4*i +: 4] != 4'd0) begin
                msd = POS_W'(i);
            end
        end

        data_next.chars = {NUM_CHARS{ASCII_SPACE}};
        data_next.start = LAST_POS;
        unique case (in_data.command)
            CMD_DEC:
            begin
                for (int j = 1; j < NUM_CHARS; j++) begin
                    data_next.chars[j] = ASCII_ZERO + {4'd0, in_data.bcd[4*(10-j) +: 4]};
                end
                for (int j = 0; j < NUM_CHARS; j++) begin
                    if (in_data.neg && (POS_W'(j) == DEC_MINUS_TOP - msd)) begin
                        data_next.chars[j] = ASCII_MINUS;
                    end
                end
                data_next.start = in_data.neg ? (DEC_MINUS_TOP - msd) : (LAST_POS - msd);
            end
            CMD_HEX:
            begin
                for (int j = 3; j < NUM_CHARS; j++) begin
                    data_next.chars[j] = HEX_TABLE[in_data.word[4*(10-j) +: 4]];
                end
                data_next.start = HEX_START;
            end
            CMD_PCT:
            begin
                data_next.chars[10] = ASCII_PERCENT;
                data_next.start     = PCT_START;
            end
            CMD_UNK:
            begin
                data_next.chars[9]  = ASCII_PERCENT;
                data_next.chars[10] = in_data.spec_char;
                data_next.start     = UNK_START;
            end
            default:
            begin
                data_next.start = LAST_POS;
            end
        endcase
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end
endmodule
`default_nettype wire

[src/fsa_serializer.sv]
`default_nettype none
module fsa_serializer (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire fsa_pkg::fsa_fmt_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output fsa_pkg::fsa_rsp_t     out_data
);
    import fsa_pkg::*;

    logic                      valid_reg;
    logic [NUM_CHARS-1:0][7:0] chars_reg;
    logic [POS_W-1:0]          idx_reg;
    logic                      at_last;

    assign at_last   = (idx_reg == LAST_POS);
    assign in_ready  = !valid_reg || (out_ready && at_last);
    assign out_valid = valid_reg;
    assign out_data  = '{out_char: chars_reg[idx_reg], last: at_last};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= LAST_POS;
        end else if (in_ready) begin
            valid_reg <= in_valid;
            idx_reg   <= in_data.start;
        end else if (out_ready) begin
            idx_reg <= idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            chars_reg <= in_data.chars;
        end
    end
endmodule
`default_nettype wire

[src/format_specifier_to_ascii_unit.sv]
// The first character of a request is offered by the serializer once the request has passed
// the entry register, the four binary-to-BCD stages and the format register. The serializer
// gives one character per cycle while rsp_ready is high; a request has one to eleven characters.
// The conversion pipeline (entry, four binary-to-BCD stages, format) takes a request each
// cycle unless it is full, and holds up to six more requests while the character serializer is busy.
// Reset (rst_n, asynchronous, active low) empties every stage; no word is in flight after it.
`default_nettype none
module format_specifier_to_ascii_unit (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_ready,
    input  wire fsa_pkg::fsa_req_t req,
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    output fsa_pkg::fsa_rsp_t     rsp
);
    import fsa_pkg::*;

    // Entry stage: take the request and split the decimal operand into sign and
    // magnitude. The most negative word negates to itself, which as an unsigned
    // magnitude is exactly 2147483648.
    logic      entry_valid_reg;
    fsa_work_t entry_reg;
    fsa_work_t entry_next;
    logic      dec_neg;

    assign dec_neg = (req.command == CMD_DEC) && req.operand_word[WORD_W-1];

    always_comb
    begin
        entry_next.command   = req.command;
        entry_next.spec_char = req.spec_char;
        entry_next.neg       = dec_neg;
        entry_next.word      = req.operand_word;
        entry_next.bcd       = '0;
        entry_next.shreg     = dec_neg ? (WORD_W'(0) - req.operand_word) : req.operand_word;
    end

    // Stage chain: index 0 is the entry register, the last index feeds the format stage.
    logic      st_valid [NUM_DD_STAGES+1];
    logic      st_ready [NUM_DD_STAGES+1];
    fsa_work_t st_data  [NUM_DD_STAGES+1];

    assign st_valid[0] = entry_valid_reg;
    assign st_data[0]  = entry_reg;
    assign req_ready   = !entry_valid_reg || st_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            entry_valid_reg <= 1'b0;
        end else if (req_ready) begin
            entry_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid) begin
            entry_reg <= entry_next;
        end
    end

    // Binary-to-BCD conversion, a quarter of the magnitude bits per stage.
    for (genvar g = 0; g < NUM_DD_STAGES; g++) begin : g_dd
        fsa_dd_stage u_dd (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (st_valid[g]),
            .in_ready  (st_ready[g]),
            .in_data   (st_data[g]),
            .out_valid (st_valid[g+1]),
            .out_ready (st_ready[g+1]),
            .out_data  (st_data[g+1])
        );
    end

    // Character layout: digits, sign and start position per command.
    logic     fmt_valid;
    logic     fmt_ready;
    fsa_fmt_t fmt_data;

    fsa_format u_format (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (st_valid[NUM_DD_STAGES]),
        .in_ready  (st_ready[NUM_DD_STAGES]),
        .in_data   (st_data[NUM_DD_STAGES]),
        .out_valid (fmt_valid),
        .out_ready (fmt_ready),
        .out_data  (fmt_data)
    );

    // One character per output word; the last position always carries the last flag.
    fsa_serializer u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fmt_valid),
        .in_ready  (fmt_ready),
        .in_data   (fmt_data),
        .out_valid (rsp_valid),
        .out_ready (rsp_ready),
        .out_data  (rsp)
    );
endmodule
`default_nettype wire

[src/fsa_checker.sv]
`default_nettype none
module fsa_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             req_valid,
    input wire logic             req_ready,
    input wire fsa_pkg::fsa_req_t req,
    input wire logic             rsp_valid,
    input wire logic             rsp_ready,
    input wire fsa_pkg::fsa_rsp_t rsp
);
    import fsa_pkg::*;

    // Requests taken whose last character has not yet been taken.
    logic [3:0] open_reg;
    logic [3:0] open_next;
    logic       req_fire;
    logic       rsp_done;

    assign req_fire  = req_valid && req_ready;
    assign rsp_done  = rsp_valid && rsp_ready && rsp.last;
    assign open_next = open_reg + {3'd0, req_fire} - {3'd0, rsp_done};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            open_reg <= '0;
        end else begin
            open_reg <= open_next;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("stalled output word changed");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> open_reg != 4'd0)
        else $error("output word without an open request");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg <= 4'd7)
        else $error("more requests open than the pipeline holds");

    // A clock edge seen in reset leaves the output idle at the next edge.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !rsp_valid)
        else $error("output valid after a reset cycle");
endmodule

bind format_specifier_to_ascii_unit fsa_checker u_fsa_checker (.*);
`default_nettype wire

[bench/fsa_text_checker.sv]
`timescale 1ns / 1ps
module fsa_text_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    input  wire logic              req_ready,
    input  wire fsa_pkg::fsa_req_t req,
    input  wire logic              rsp_valid,
    input  wire logic              rsp_ready,
    input  wire fsa_pkg::fsa_rsp_t rsp,
    output int unsigned            chars_pending,
    output int unsigned            error_count
);
    import fsa_pkg::*;

    // Characters still owed by the block, oldest first.
    fsa_rsp_t expected_text[$];

    initial
    begin
        chars_pending = 0;
        error_count   = 0;
    end

    // Appends the characters that one request must produce.
    function automatic void render_request(input fsa_req_t r);
        logic [7:0]  chars[$];
        logic [7:0]  digits[$];
        logic [31:0] magnitude;
        logic [3:0]  nibble;
        fsa_rsp_t    ch;
        case (r.command)
            CMD_DEC:
            begin
                if (r.operand_word == 32'd0) begin
                    chars.push_back(ASCII_ZERO);
                end else begin
                    magnitude = r.operand_word;
                    if (r.operand_word[31]) begin
                        chars.push_back(ASCII_MINUS);
                        magnitude = -r.operand_word;
                    end
                    while (magnitude != 32'd0) begin
                        digits.push_front(ASCII_ZERO + 8'(magnitude % 32'd10));
                        magnitude = magnitude / 32'd10;
                    end
                    foreach (digits[i]) chars.push_back(digits[i]);
                end
            end
            CMD_HEX:
            begin
                for (int shift = 28; shift >= 0; shift -= 4) begin
                    nibble = r.operand_word[shift +: 4];
                    chars.push_back(nibble < 4'd10 ? ASCII_ZERO + 8'(nibble)
                                                   : 8'h61 + 8'(nibble - 4'd10));
                end
            end
            CMD_PCT:
            begin
                chars.push_back(ASCII_PERCENT);
            end
            default:
            begin
                chars.push_back(ASCII_PERCENT);
                chars.push_back(r.spec_char);
            end
        endcase
        foreach (chars[i]) begin
            ch.out_char = chars[i];
            ch.last     = (i == chars.size() - 1);
            expected_text.push_back(ch);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        fsa_rsp_t want;
        if (!rst_n) begin
            expected_text.delete();
            chars_pending <= 0;
        end else begin
            if (req_valid && req_ready) begin
                render_request(req);
            end
            if (rsp_valid && rsp_ready) begin
                if (expected_text.size() == 0) begin
                    if (error_count < 10) begin
                        $display("%0t: unexpected char 0x%02h last %0b", $realtime,
                                 rsp.out_char, rsp.last);
                    end
                    error_count++;
                end else begin
                    want = expected_text.pop_front();
                    if (rsp.out_char !== want.out_char || rsp.last !== want.last) begin
                        if (error_count < 10) begin
                            $display("%0t: expected char 0x%02h last %0b, got 0x%02h last %0b",
                                     $realtime, want.out_char, want.last,
                                     rsp.out_char, rsp.last);
                        end
                        error_count++;
                    end
                end
            end
            chars_pending <= expected_text.size();
        end
    end

endmodule

[bench/format_specifier_to_ascii_unit_test.sv]
`timescale 1ns / 1ps
module format_specifier_to_ascii_unit_test;
    import fsa_pkg::*;

    // Cycles with no word accepted on either channel before the run is
    // declared hung. A correct run never goes near this: the longest quiet
    // stretch is a sender gap plus the pipeline latency plus a receiver stall.
    localparam int unsigned STALL_LIMIT = 2000;
    // Random requests per idling phase; the four phases and the directed
    // requests give about 150 in all.
    localparam int PHASE_ITEMS = 32;
    // Quiet cycles after the last character, to catch anything extra.
    localparam int DRAIN_CYCLES = 30;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    fsa_req_t req       = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    fsa_rsp_t rsp;

    int unsigned chars_pending;
    int unsigned error_count;
    int unsigned quiet_cycles = 0;

    // Percent of cycles in which the sender holds back and the receiver stalls.
    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;

    format_specifier_to_ascii_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // The checker watches both channels, predicts every character and
    // compares; this module only makes stimulus and gives the verdict.
    fsa_text_checker u_text_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req           (req),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .rsp           (rsp),
        .chars_pending (chars_pending),
        .error_count   (error_count)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // The receiver stalls independently each cycle, so stalls land on every
    // character position of a request, the first and the last among them.
    always @(posedge clk)
    begin
        rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Watchdog: any accepted word on either side restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one request and returns in the time step of the edge that took it.
    // Valid stays high into the next request unless a gap is drawn, so that
    // back-to-back words go through without a bubble.
    task automatic send_request(input fsa_req_t r);
        while ($urandom_range(99) < sender_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    task automatic send_fields(input logic [1:0] command, input logic [31:0] word,
                               input logic [7:0] spec);
        fsa_req_t r;
        r.command      = command;
        r.operand_word = word;
        r.spec_char    = spec;
        send_request(r);
    endtask

    // Holds the sender off until every predicted character has come out.
    // The checker updates its count with a nonblocking assignment, so one edge passes first.
    task automatic wait_for_text();
        req_valid <= 1'b0;
        @(posedge clk);
        while (chars_pending != 0) @(posedge clk);
    endtask

    // Random request. Decimal is weighted heaviest, since it has the most
    // varied lengths; operands mix full-range words, short numbers of either
    // sign and values next to powers of ten, where the digit count changes.
    function automatic fsa_req_t random_request();
        fsa_req_t    r;
        int unsigned pick;
        int unsigned power;
        pick = $urandom_range(99);
        if (pick < 50) begin
            r.command = CMD_DEC;
        end else if (pick < 75) begin
            r.command = CMD_HEX;
        end else if (pick < 85) begin
            r.command = CMD_PCT;
        end else begin
            r.command = CMD_UNK;
        end
        case ($urandom_range(3))
            0: r.operand_word = $urandom;
            1: r.operand_word = $urandom_range(999);
            2: r.operand_word = -$urandom_range(999, 1);
            default:
            begin
                power = 1;
                repeat ($urandom_range(9)) power = power * 10;
                r.operand_word = power - 1 + $urandom_range(2);
                if ($urandom_range(1)) r.operand_word = -r.operand_word;
            end
        endcase
        r.spec_char = $urandom_range(255);
        return r;
    endfunction

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, no idling: decimal zero, the shortest and longest
        // numbers, both ends of the signed range including the most negative
        // value, hex extremes, the literal percent, and unknown specifiers
        // that echo a percent sign, format letters, zero and an all-ones byte.
        send_fields(CMD_DEC, 32'd0, 8'h00);
        send_fields(CMD_DEC, 32'd1, 8'hff);
        send_fields(CMD_DEC, 32'd9, 8'h00);
        send_fields(CMD_DEC, 32'd10, 8'h00);
        send_fields(CMD_DEC, 32'hffff_ffff, 8'h00);
        send_fields(CMD_DEC, -32'd10, 8'h00);
        send_fields(CMD_DEC, 32'd1_000_000_000, 8'h00);
        send_fields(CMD_DEC, 32'h7fff_ffff, 8'h00);
        send_fields(CMD_DEC, 32'h8000_0000, 8'h00);
        send_fields(CMD_DEC, 32'h8000_0001, 8'h00);
        send_fields(CMD_HEX, 32'h0000_0000, 8'h00);
        send_fields(CMD_HEX, 32'hffff_ffff, 8'hff);
        send_fields(CMD_HEX, 32'h0123_4567, 8'h00);
        send_fields(CMD_HEX, 32'h89ab_cdef, 8'h00);
        send_fields(CMD_PCT, 32'hffff_ffff, 8'hff);
        send_fields(CMD_PCT, 32'h0000_0000, 8'h00);
        send_fields(CMD_UNK, 32'h0000_0000, ASCII_PERCENT);
        send_fields(CMD_UNK, 32'hffff_ffff, 8'h64);
        send_fields(CMD_UNK, 32'h0000_0000, 8'h78);
        send_fields(CMD_UNK, 32'h0000_0000, 8'h00);
        send_fields(CMD_UNK, 32'h0000_0000, 8'hff);

        // The sender pauses here until the block has emptied.
        wait_for_text();

        // Random part in four idling phases: none, sender gaps, receiver
        // stalls, then both. The block is drained between phases.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 52;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 52;
                end
                default:
                begin
                    sender_idle_pct    = 30;
                    receiver_stall_pct = 30;
                end
            endcase
            repeat (PHASE_ITEMS) send_request(random_request());
            wait_for_text();
        end

        // Anything the block still emits now is unexpected and gets flagged.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && chars_pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
